// ===== hw/rtl/fir_pkg.sv =====
package fir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 18;
    localparam int PROD_W   = SAMPLE_W + TAP_W;
    localparam int CFG_W    = 9;
    localparam int INDEX_W  = 8;

    // Q2.31 products back to Q0.15: bias by half an LSB, then drop 16 bits
    localparam int ROUND_SHIFT = 16;
    localparam int ROUND_HALF  = 32768;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_TAP    = 1'b1;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// ===== hw/rtl/fir_ram.sv =====
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fir_mac.sv =====
module fir_mac #(
    parameter int ACC_W = 42
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fir_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic signed [fir_pkg::TAP_W-1:0]     i_tap,
    output logic signed [ACC_W-1:0]              o_acc,
    output logic                                 o_done
);

    logic signed [fir_pkg::PROD_W-1:0] r_prod;
    fir_pkg::t_mac_ctl                 r_pctl;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [ACC_W-1:0]           n_acc;
    logic                              r_done;

    always_comb begin
        n_acc = r_acc;
        if (r_pctl.valid) begin
            // restart the sum on the first tap
            n_acc = (r_pctl.first ? '0 : r_acc)
                  + {{(ACC_W-fir_pkg::PROD_W){r_prod[fir_pkg::PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_tap;
        r_acc  <= n_acc;
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_pctl <= i_ctl;
            r_done <= r_pctl.valid && r_pctl.last;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/fir_ring_buffer_filter.sv =====
// Mode 0 item: n = active taps (1..MAX_TAPS) are read, multiplied and summed; the sum is
// rounded and registered with o_valid. One shared multiply-accumulate takes one tap per
// cycle; a filtered item keeps o_ready low until its sum is loaded, a tap write (mode 1)
// leaves it high. Reset (synchronous, active low) starts a clearing pass that zeroes the
// sample ring and the tap store; o_ready stays low during it, config writes are taken.
module fir_ring_buffer_filter #(
    parameter int MAX_TAPS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_mode,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic [fir_pkg::INDEX_W-1:0]          i_tap_index,
    input  logic signed [fir_pkg::TAP_W-1:0]     i_tap_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [fir_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fir_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int NW    = $clog2(MAX_TAPS + 1);
    localparam int CW    = (NW > fir_pkg::CFG_W) ? NW : fir_pkg::CFG_W;
    localparam int ACC_W = fir_pkg::PROD_W + $clog2(MAX_TAPS);
    localparam int RW    = ACC_W + 1;
    localparam int HI_LO = fir_pkg::ROUND_SHIFT + fir_pkg::SAMPLE_W - 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_WAIT  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [AW-1:0]                   r_clr_addr, n_clr_addr;
    logic [fir_pkg::CFG_W-1:0]       r_tap_count;
    logic [AW-1:0]                   r_pos, n_pos;
    logic [AW-1:0]                   r_rd_pos, n_rd_pos;
    logic [AW-1:0]                   r_j, n_j;
    fir_pkg::t_mac_ctl               issue_ctl, r_ctl_d;
    logic signed [RW-1:0]            r_rnd;
    logic                            r_rnd_vld, n_rnd_vld;
    logic                            r_out_vld, n_out_vld;
    logic signed [fir_pkg::SAMPLE_W-1:0] r_out, n_out;

    logic [CW-1:0]                   tc_ext;
    logic [CW-1:0]                   eff_w;
    logic [NW-1:0]                   n_taps;
    logic [AW-1:0]                   wpos;
    logic [NW-1:0]                   wpos_inc;
    logic [NW-1:0]                   rd_inc;
    logic                            accept;
    logic                            load_out;

    logic                            ring_we;
    logic [AW-1:0]                   ring_waddr;
    logic [fir_pkg::SAMPLE_W-1:0]    ring_wdata;
    logic [fir_pkg::SAMPLE_W-1:0]    ring_rdata;
    logic                            tap_we;
    logic [AW-1:0]                   tap_waddr;
    logic [fir_pkg::TAP_W-1:0]       tap_wdata;
    logic [fir_pkg::TAP_W-1:0]       tap_rdata;

    logic signed [ACC_W-1:0]         mac_acc;
    logic                            mac_done;
    logic [RW-1:HI_LO]               rnd_hi;

    // effective length: zero acts as one, clamp to the store depth
    always_comb begin
        tc_ext = CW'(r_tap_count);
        if (tc_ext == '0) begin
            eff_w = CW'(1);
        end else if (tc_ext > CW'(MAX_TAPS)) begin
            eff_w = CW'(MAX_TAPS);
        end else begin
            eff_w = tc_ext;
        end
        n_taps = NW'(eff_w);
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // write position wraps if the length was lowered
    assign wpos     = (NW'(r_pos) >= n_taps) ? '0 : r_pos;
    assign wpos_inc = NW'(wpos) + NW'(1);
    assign rd_inc   = NW'(r_rd_pos) + NW'(1);

    always_comb begin
        issue_ctl.valid = (r_state == S_ISSUE);
        issue_ctl.first = (r_j == '0);
        issue_ctl.last  = ((NW'(r_j) + NW'(1)) == n_taps);
    end

    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = wpos;
        ring_wdata = i_sample_in;
        tap_we     = 1'b0;
        tap_waddr  = AW'(i_tap_index);
        tap_wdata  = i_tap_value;
        if (r_state == S_CLEAR) begin
            ring_we    = 1'b1;
            ring_waddr = r_clr_addr;
            ring_wdata = '0;
            tap_we     = 1'b1;
            tap_waddr  = r_clr_addr;
            tap_wdata  = '0;
        end else if (accept) begin
            ring_we = (i_mode == fir_pkg::MODE_FILTER);
            tap_we  = (i_mode == fir_pkg::MODE_TAP) && (int'(i_tap_index) < MAX_TAPS);
        end
    end

    assign load_out = (r_state == S_WAIT) && r_rnd_vld && (!r_out_vld || i_ready);

    // saturate: the bits above the Q0.15 result must all match its sign
    assign rnd_hi = r_rnd[RW-1:HI_LO];
    always_comb begin
        if ((&rnd_hi) || !(|rnd_hi)) begin
            n_out = r_rnd[HI_LO:fir_pkg::ROUND_SHIFT];
        end else if (r_rnd[RW-1]) begin
            n_out = fir_pkg::SAT_MIN;
        end else begin
            n_out = fir_pkg::SAT_MAX;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_pos      = r_pos;
        n_rd_pos   = r_rd_pos;
        n_j        = r_j;
        n_rnd_vld  = r_rnd_vld;
        n_out_vld  = r_out_vld;
        if (o_valid && i_ready) begin
            n_out_vld = 1'b0;
        end
        if (mac_done) begin
            n_rnd_vld = 1'b1;
        end
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_TAPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (i_mode == fir_pkg::MODE_FILTER)) begin
                    // oldest sample sits at the advanced position
                    n_pos    = (wpos_inc >= n_taps) ? '0 : AW'(wpos_inc);
                    n_rd_pos = n_pos;
                    n_j      = '0;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_rd_pos = (rd_inc >= n_taps) ? '0 : AW'(rd_inc);
                n_j      = r_j + AW'(1);
                if (issue_ctl.last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (load_out) begin
                    n_rnd_vld = 1'b0;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mac_done) begin
            r_rnd <= $signed({mac_acc[ACC_W-1], mac_acc}) + RW'(fir_pkg::ROUND_HALF);
        end
        if (load_out) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_tap_count <= fir_pkg::CFG_W'(1);
            r_pos       <= '0;
            r_rd_pos    <= '0;
            r_j         <= '0;
            r_ctl_d     <= '0;
            r_rnd_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
            r_pos     <= n_pos;
            r_rd_pos  <= n_rd_pos;
            r_j       <= n_j;
            r_ctl_d   <= issue_ctl;
            r_rnd_vld <= n_rnd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out;

    fir_ram #(
        .WIDTH (fir_pkg::SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (r_rd_pos),
        .o_rdata (ring_rdata)
    );

    fir_ram #(
        .WIDTH (fir_pkg::TAP_W),
        .DEPTH (MAX_TAPS)
    ) u_taps (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (tap_wdata),
        .i_raddr (r_j),
        .o_rdata (tap_rdata)
    );

    fir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl_d),
        .i_sample ($signed(ring_rdata)),
        .i_tap    ($signed(tap_rdata)),
        .o_acc    (mac_acc),
        .o_done   (mac_done)
    );

endmodule

// ===== hw/rtl/fir_chk.sv =====
module fir_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            i_mode,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [fir_pkg::SAMPLE_W-1:0]    o_sample_out
);

    // a result held back by the consumer keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out))
        else $error("result changed or dropped while stalled");

    // a tap write leaves the block ready for the next item
    a_tap_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode == fir_pkg::MODE_TAP) |=> o_ready)
        else $error("block busy after a tap write");

    // a filter item drops o_ready once it is accepted
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode == fir_pkg::MODE_FILTER) |=> !o_ready)
        else $error("block ready straight after a filter item");

    // no result can appear early after a filter item
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode == fir_pkg::MODE_FILTER)
        |=> !$rose(o_valid) ##1 !$rose(o_valid))
        else $error("result arrived too early");

endmodule

bind fir_ring_buffer_filter fir_chk u_fir_chk (.*);
